>>> hw/rtl/cvct_pkg.sv
// ----------------------------------------------------------------------------
// cvct_pkg
// Shared constants and types for the convex volume cull test unit: register
// map, configuration port widths and the packed plane layout.
// ----------------------------------------------------------------------------
package cvct_pkg;

    // Plane slots present in the register map
    localparam int CVCT_MAX_PLANES = 6;
    localparam int NUM_PLANE_REGS  = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W    = 3;

    // Fraction bits of the Q2.14 plane normal
    localparam int Q_FRAC = 14;

    // Beats in flight between input and output at most (four register stages)
    localparam int PIPE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_0     = 3'd1;

    // Packed plane register: d in the top half-word, nx in the bottom one
    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } plane_t;

endpackage

>>> hw/rtl/convex_volume_cull_test_unit.sv
// ----------------------------------------------------------------------------
// convex_volume_cull_test_unit
// Tests an axis-aligned box or a sphere against up to MAX_PLANES configured
// planes and reports whether it lies inside or intersects all of them.
// ----------------------------------------------------------------------------
// Usage: write plane_count (index 0) and the packed planes (indexes 1..6)
// while the unit is idle, then stream one object per beat on the input
// channel. Each object gives exactly one inside_res beat, in order. The unit
// accepts a beat every cycle unless the output stalls with every stage full;
// a result passes through the four register stages (input capture on the
// accepting edge, one bank of multipliers per plane, per-plane distance and
// radius sums, compare and reduce into the output register). Every plane has
// its own multipliers, so the plane count never changes the rate. A stalled
// output holds its beat while the stages behind it keep filling up to four
// beats; bubbles are squeezed out.
// All arithmetic is exact: distances are kept in Q.14 units at 33 bits, so
// no saturation is needed. A plane count above MAX_PLANES uses MAX_PLANES;
// a count of zero passes every object.
module convex_volume_cull_test_unit #(
    parameter int MAX_PLANES = cvct_pkg::CVCT_MAX_PLANES
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write port
    input  logic                            cfg_we,
    input  logic [cvct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvct_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Object channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic signed [15:0]              center_x,
    input  logic signed [15:0]              center_y,
    input  logic signed [15:0]              center_z,
    input  logic signed [15:0]              half_x,
    input  logic signed [15:0]              half_y,
    input  logic signed [15:0]              half_z,
    input  logic signed [15:0]              radius,

    // Result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res
);

    import cvct_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] plane_count_reg;
    plane_t             plane_reg [MAX_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_PLANE_COUNT)
        begin
            plane_count_reg <= cfg_wdata[COUNT_W-1:0];
        end
    end

    // Plane slots beyond MAX_PLANES are never read; writes to them drop.
    for (genvar p = 0; p < MAX_PLANES; p++)
    begin : g_plane_regs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[p] <= '0;
            end
            else if (cfg_we && cfg_index == REG_PLANE_0 + CFG_IDX_W'(p))
            begin
                plane_reg[p] <= plane_t'(cfg_wdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a new beat when it is empty or when
    // the stage ahead of it takes its current beat.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_adv, s2_adv, s3_adv, s4_adv;

    assign s4_adv   = !out_valid_reg || out_ready;
    assign s3_adv   = !s3_valid_reg  || s4_adv;
    assign s2_adv   = !s2_valid_reg  || s3_adv;
    assign s1_adv   = !s1_valid_reg  || s2_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg  <= in_valid;
            if (s2_adv) s2_valid_reg  <= s1_valid_reg;
            if (s3_adv) s3_valid_reg  <= s2_valid_reg;
            if (s4_adv) out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the object, take the magnitude of the half sizes
    // (|-32768| needs the 17th bit) and latch which planes are enabled.
    // ------------------------------------------------------------------
    logic                   s1_sphere_reg;
    logic signed [15:0]     s1_cx_reg, s1_cy_reg, s1_cz_reg, s1_rad_reg;
    logic [16:0]            s1_hx_reg, s1_hy_reg, s1_hz_reg;
    logic [MAX_PLANES-1:0]  s1_mask_reg;
    logic [MAX_PLANES-1:0]  s1_mask_next;
    logic [16:0]            hx_abs_next, hy_abs_next, hz_abs_next;

    always_comb
    begin
        hx_abs_next = half_x[15] ? 17'(-{half_x[15], half_x}) : {1'b0, half_x};
        hy_abs_next = half_y[15] ? 17'(-{half_y[15], half_y}) : {1'b0, half_y};
        hz_abs_next = half_z[15] ? 17'(-{half_z[15], half_z}) : {1'b0, half_z};
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            // Lanes only exist up to MAX_PLANES, so this also clamps the count
            s1_mask_next[p] = (plane_count_reg > COUNT_W'(p));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_sphere_reg <= req_type;
            s1_cx_reg     <= center_x;
            s1_cy_reg     <= center_y;
            s1_cz_reg     <= center_z;
            s1_hx_reg     <= hx_abs_next;
            s1_hy_reg     <= hy_abs_next;
            s1_hz_reg     <= hz_abs_next;
            s1_rad_reg    <= radius;
            s1_mask_reg   <= s1_mask_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3 per plane: products, then the two sums.
    // ------------------------------------------------------------------
    logic                   s2_sphere_reg;
    logic signed [15:0]     s2_rad_reg;
    logic [MAX_PLANES-1:0]  s2_mask_reg;
    logic [MAX_PLANES-1:0]  s3_mask_reg;
    logic signed [32:0]     s3_dist_reg [MAX_PLANES];
    logic signed [32:0]     s3_eff_reg  [MAX_PLANES];
    logic [MAX_PLANES-1:0]  fail_next;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_sphere_reg <= s1_sphere_reg;
            s2_rad_reg    <= s1_rad_reg;
            s2_mask_reg   <= s1_mask_reg;
        end
        if (s3_adv)
        begin
            s3_mask_reg <= s2_mask_reg;
        end
    end

    for (genvar p = 0; p < MAX_PLANES; p++)
    begin : g_lane
        logic [16:0]        nx_abs, ny_abs, nz_abs;
        logic signed [31:0] px_next, py_next, pz_next;
        logic [33:0]        ex_full, ey_full, ez_full;
        logic signed [31:0] s2_px_reg, s2_py_reg, s2_pz_reg;
        logic [30:0]        s2_ex_reg, s2_ey_reg, s2_ez_reg;
        logic [31:0]        eff_box;
        logic signed [32:0] dist_next, eff_next;
        logic signed [33:0] margin;

        // Normal magnitudes come from static configuration
        always_comb
        begin
            nx_abs = plane_reg[p].nx[15] ? 17'(-{plane_reg[p].nx[15], plane_reg[p].nx})
                                         : {1'b0, plane_reg[p].nx};
            ny_abs = plane_reg[p].ny[15] ? 17'(-{plane_reg[p].ny[15], plane_reg[p].ny})
                                         : {1'b0, plane_reg[p].ny};
            nz_abs = plane_reg[p].nz[15] ? 17'(-{plane_reg[p].nz[15], plane_reg[p].nz})
                                         : {1'b0, plane_reg[p].nz};
            px_next = s1_cx_reg * plane_reg[p].nx;
            py_next = s1_cy_reg * plane_reg[p].ny;
            pz_next = s1_cz_reg * plane_reg[p].nz;
            // Each magnitude product is at most 2^30
            ex_full = s1_hx_reg * nx_abs;
            ey_full = s1_hy_reg * ny_abs;
            ez_full = s1_hz_reg * nz_abs;
        end

        always_ff @(posedge clk)
        begin
            if (s2_adv)
            begin
                s2_px_reg <= px_next;
                s2_py_reg <= py_next;
                s2_pz_reg <= pz_next;
                s2_ex_reg <= ex_full[30:0];
                s2_ey_reg <= ey_full[30:0];
                s2_ez_reg <= ez_full[30:0];
            end
        end

        always_comb
        begin
            eff_box   = 32'(s2_ex_reg) + 32'(s2_ey_reg) + 32'(s2_ez_reg);
            dist_next = 33'(s2_px_reg) + 33'(s2_py_reg) + 33'(s2_pz_reg)
                        - (33'(plane_reg[p].d) <<< Q_FRAC);
            // A negative sphere radius is used with its sign
            eff_next  = s2_sphere_reg ? (33'(s2_rad_reg) <<< Q_FRAC)
                                      : $signed({1'b0, eff_box});
        end

        always_ff @(posedge clk)
        begin
            if (s3_adv)
            begin
                s3_dist_reg[p] <= dist_next;
                s3_eff_reg[p]  <= eff_next;
            end
        end

        // dist < -eff is the same as dist + eff going negative
        assign margin       = 34'(s3_dist_reg[p]) + 34'(s3_eff_reg[p]);
        assign fail_next[p] = margin[33];
    end

    // ------------------------------------------------------------------
    // Stage 4: reduce over enabled planes into the output register.
    // ------------------------------------------------------------------
    logic inside_res_reg;
    logic inside_res_next;

    assign inside_res_next = ~|(fail_next & s3_mask_reg);

    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            inside_res_reg <= inside_res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

endmodule

>>> hw/rtl/cvct_checker.sv
// ----------------------------------------------------------------------------
// cvct_checker
// Port-level checks for the convex volume cull test unit, bound to the top.
// ----------------------------------------------------------------------------
module cvct_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [cvct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [cvct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            inside_res
);

    import cvct_pkg::*;

    // Track beats in flight and whether the plane count is zero
    logic [2:0] inflight_reg, inflight_next;
    logic       no_planes_reg;

    always_comb
    begin
        inflight_next = inflight_reg + 3'(in_valid && in_ready)
                        - 3'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= '0;
            no_planes_reg <= 1'b1;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg_we && cfg_index == REG_PLANE_COUNT)
            begin
                no_planes_reg <= (cfg_wdata[COUNT_W-1:0] == '0);
            end
        end
    end

    // Hold the result beat while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res))
        else $error("result beat changed while stalled");

    // No result beat without an object in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result beat without an accepted object");

    // Never more beats in flight than register stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    // Back pressure only when every stage is full and the output stalls
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && inflight_reg == 3'(PIPE_DEPTH))
        else $error("input stalled with room in the pipeline");

    // With no planes enabled every object passes
    a_no_planes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_planes_reg |-> inside_res)
        else $error("object culled with no planes enabled");

endmodule

bind convex_volume_cull_test_unit cvct_checker u_cvct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res)
);

>>> test/convex_volume_cull_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// convex_volume_cull_checker
// Watches the configuration port and both beat channels of the cull test
// unit, keeps its own copy of the plane registers, works out the inside or
// culled verdict of every accepted object and compares it with the result
// beats in order.
// ----------------------------------------------------------------------------
module convex_volume_cull_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cvct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            req_type,
    input  logic signed [15:0]              center_x,
    input  logic signed [15:0]              center_y,
    input  logic signed [15:0]              center_z,
    input  logic signed [15:0]              half_x,
    input  logic signed [15:0]              half_y,
    input  logic signed [15:0]              half_z,
    input  logic signed [15:0]              radius,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            inside_res,
    output int                              fail_count,
    output int                              pending
);

    import cvct_pkg::*;

    logic [COUNT_W-1:0] plane_count;
    plane_t             plane_bank [NUM_PLANE_REGS];
    logic               verdict_q [$];

    initial
    begin
        fail_count = 0;
    end

    task automatic note_mismatch(input string what);
        fail_count++;
        $display("%0t ns verdict_check: %s", $time, what);
    endtask

    // Rejected as soon as the distance falls below minus the reach on any
    // enabled plane; all products kept exact in 64 bits.
    function automatic logic cull_verdict(
        input logic               sphere,
        input logic signed [15:0] cx,
        input logic signed [15:0] cy,
        input logic signed [15:0] cz,
        input logic signed [15:0] hx,
        input logic signed [15:0] hy,
        input logic signed [15:0] hz,
        input logic signed [15:0] rad
    );
        longint             plane_dist;
        longint             reach;
        longint             ax;
        longint             ay;
        longint             az;
        int                 used;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [15:0] dd;
        logic               verdict;
        verdict = 1'b1;
        used = (plane_count > CVCT_MAX_PLANES) ? CVCT_MAX_PLANES : int'(plane_count);
        ax = (hx < 0) ? -longint'(hx) : longint'(hx);
        ay = (hy < 0) ? -longint'(hy) : longint'(hy);
        az = (hz < 0) ? -longint'(hz) : longint'(hz);
        for (int p = 0; p < used; p++)
        begin
            nx = plane_bank[p].nx;
            ny = plane_bank[p].ny;
            nz = plane_bank[p].nz;
            dd = plane_bank[p].d;
            plane_dist = longint'(cx) * longint'(nx) + longint'(cy) * longint'(ny)
                       + longint'(cz) * longint'(nz) - (longint'(dd) <<< Q_FRAC);
            if (sphere)
            begin
                reach = longint'(rad) <<< Q_FRAC;
            end
            else
            begin
                reach = ax * ((nx < 0) ? -longint'(nx) : longint'(nx))
                      + ay * ((ny < 0) ? -longint'(ny) : longint'(ny))
                      + az * ((nz < 0) ? -longint'(nz) : longint'(nz));
            end
            if (plane_dist < -reach)
            begin
                verdict = 1'b0;
            end
        end
        return verdict;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            plane_count = '0;
            for (int p = 0; p < NUM_PLANE_REGS; p++)
            begin
                plane_bank[p] = '0;
            end
            verdict_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PLANE_COUNT)
                begin
                    plane_count = cfg_wdata[COUNT_W-1:0];
                end
                else if (cfg_index >= REG_PLANE_0 && cfg_index < REG_PLANE_0 + NUM_PLANE_REGS)
                begin
                    plane_bank[cfg_index - REG_PLANE_0] = cfg_wdata;
                end
            end
            if (in_valid && in_ready)
            begin
                verdict_q.push_back(cull_verdict(req_type, center_x, center_y, center_z,
                                                 half_x, half_y, half_z, radius));
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    note_mismatch("result beat with no object outstanding");
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want)
                    begin
                        note_mismatch($sformatf("inside_res %b, predicted %b", inside_res, want));
                    end
                end
            end
            pending <= verdict_q.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams boxes and spheres into the convex volume cull test unit under
// several plane sets and plane counts, with random gaps on the input side
// and random stalls on the result side. A checker beside the unit predicts
// every verdict; this module makes the stimulus and calls the outcome.
// ----------------------------------------------------------------------------
module tb;
    import cvct_pkg::*;

    // First index past the plane registers; writes here must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_PLANE_0 + CFG_IDX_W'(NUM_PLANE_REGS);
    localparam int NUM_PHASES      = 10;
    localparam int BEATS_PER_PHASE = 164;

    typedef enum int { PLANE_RAW, PLANE_AXIS, PLANE_UNIT, PLANE_EXTREME, PLANE_MIXED } plane_style_t;
    typedef enum int { COORD_FULL, COORD_NEAR, COORD_EDGE } coord_style_t;

    typedef struct packed {
        logic               sphere;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic signed [15:0] hz;
        logic signed [15:0] rad;
    } volume_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic                   req_type;
    logic signed [15:0]     center_x;
    logic signed [15:0]     center_y;
    logic signed [15:0]     center_z;
    logic signed [15:0]     half_x;
    logic signed [15:0]     half_y;
    logic signed [15:0]     half_z;
    logic signed [15:0]     radius;
    logic                   out_valid;
    logic                   out_ready;
    logic                   inside_res;
    int                     fail_count;
    int                     pending;

    plane_t                 plane_set [NUM_PLANE_REGS];
    logic [COUNT_W-1:0]     phase_counts [NUM_PHASES];
    bit                     tx_steady;

    always #1 clk = ~clk;

    convex_volume_cull_test_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .half_x     (half_x),
        .half_y     (half_y),
        .half_z     (half_z),
        .radius     (radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res)
    );

    convex_volume_cull_checker verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .half_x     (half_x),
        .half_y     (half_y),
        .half_z     (half_z),
        .radius     (radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle stretch length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_coord(input coord_style_t style);
        case (style)
            COORD_FULL: return 16'($urandom);
            // small values straddle the faces of axis planes with small offsets
            COORD_NEAR: return 16'($urandom_range(0, 256) - 128);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    3:       return 16'h0001;
                    4:       return 16'h8001;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic volume_t random_volume();
        volume_t      v;
        coord_style_t style;
        int           roll;
        roll = $urandom_range(0, 99);
        style = (roll < 45) ? COORD_NEAR : (roll < 85) ? COORD_FULL : COORD_EDGE;
        v.sphere = 1'($urandom_range(0, 1));
        v.cx  = pick_coord(style);
        v.cy  = pick_coord(style);
        v.cz  = pick_coord(style);
        v.hx  = pick_coord(style);
        v.hy  = pick_coord(style);
        v.hz  = pick_coord(style);
        v.rad = pick_coord(style);
        return v;
    endfunction

    function automatic volume_t vol(input logic sphere, input int cx, input int cy,
                                    input int cz, input int hx, input int hy,
                                    input int hz, input int rad);
        volume_t v;
        v.sphere = sphere;
        v.cx  = 16'(cx);
        v.cy  = 16'(cy);
        v.cz  = 16'(cz);
        v.hx  = 16'(hx);
        v.hy  = 16'(hy);
        v.hz  = 16'(hz);
        v.rad = 16'(rad);
        return v;
    endfunction

    function automatic logic [15:0] extreme_half();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hC000;
            3:       return 16'h4000;
            4:       return 16'hFFFF;
            5:       return 16'h8001;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic plane_t make_plane(input plane_style_t style);
        plane_t pl;
        int     axis;
        if (style == PLANE_MIXED)
            style = plane_style_t'($urandom_range(0, 3));
        case (style)
            PLANE_RAW:  pl = {$urandom, $urandom};
            PLANE_AXIS:
            begin
                axis = $urandom_range(0, 2);
                pl = '0;
                pl.d = 16'($urandom_range(0, 256) - 128);
                if (axis == 0)
                    pl.nx = $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
                else if (axis == 1)
                    pl.ny = $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
                else
                    pl.nz = $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
            end
            PLANE_UNIT:
            begin
                pl.nx = 16'($urandom_range(0, 32768) - 16384);
                pl.ny = 16'($urandom_range(0, 32768) - 16384);
                pl.nz = 16'($urandom_range(0, 32768) - 16384);
                pl.d  = 16'($urandom);
            end
            default:
            begin
                pl.nx = extreme_half();
                pl.ny = extreme_half();
                pl.nz = extreme_half();
                pl.d  = extreme_half();
            end
        endcase
        return pl;
    endfunction

    // Write the plane count (junk in its upper bits) and every plane slot,
    // optionally poking the spare index; the unit must be idle.
    task automatic load_planes(input logic [COUNT_W-1:0] count, input bit poke_spare);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= REG_PLANE_COUNT;
        cfg_wdata <= {$urandom, junk[31:COUNT_W], count};
        @(posedge clk);
        for (int p = 0; p < NUM_PLANE_REGS; p++)
        begin
            cfg_index <= REG_PLANE_0 + CFG_IDX_W'(p);
            cfg_wdata <= plane_set[p];
            @(posedge clk);
        end
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_wdata <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Present one object beat after an optional gap and hold it until taken.
    // Valid is not dropped between back-to-back beats.
    task automatic send_object(input volume_t v);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= v.sphere;
        center_x <= v.cx;
        center_y <= v.cy;
        center_z <= v.cz;
        half_x   <= v.hx;
        half_y   <= v.hy;
        half_z   <= v.hz;
        radius   <= v.rad;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold off until every predicted verdict has come back,
    // then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Result side: ready stretches of random length broken by random stalls
    initial
    begin
        int run;
        int gap;
        out_ready = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
            repeat (run)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            gap = idle_len();
            repeat (gap)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        plane_style_t style;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        center_x  = '0;
        center_y  = '0;
        center_z  = '0;
        half_x    = '0;
        half_y    = '0;
        half_z    = '0;
        radius    = '0;
        tx_steady = 1'b0;
        phase_counts = '{3'd1, 3'd6, 3'd7, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state has no planes in use: every object passes, even the
        // most negative sizes and a negative radius.
        send_object(vol(1'b0, -32768, -32768, -32768, -32768, -32768, -32768, 0));
        send_object(vol(1'b1, 32767, -32768, 32767, 0, 0, 0, -32768));
        drain();

        // One plane, x >= -reach: probe both sides of the face
        for (int p = 0; p < NUM_PLANE_REGS; p++)
            plane_set[p] = '0;
        plane_set[0].nx = 16'sh4000;
        load_planes(3'd1, 1'b0);
        send_object(vol(1'b1, -5, 100, -100, 0, 0, 0, 5));
        send_object(vol(1'b1, -6, 100, -100, 0, 0, 0, 5));
        send_object(vol(1'b0, -7, 3, 3, 7, 1, 1, 0));
        send_object(vol(1'b0, -8, 3, 3, -7, 1, 1, 0));
        send_object(vol(1'b0, -7, 3, 3, -7, 1, 1, 0));
        send_object(vol(1'b0, -8, 3, 3, 7, 1, 1, 0));
        // most negative half size counts as +32768, exactly on the face
        send_object(vol(1'b0, -32768, 0, 0, -32768, 0, 0, 0));
        // negative radius tightens the test to x >= |radius|
        send_object(vol(1'b1, 3, 0, 0, 0, 0, 0, -3));
        send_object(vol(1'b1, 2, 0, 0, 0, 0, 0, -3));
        drain();

        // Count of seven saturates to six, so only the last slot can cull;
        // also poke the unused index, which must leave the planes alone.
        plane_set[0] = '0;
        plane_set[5].nx = -16'sh4000;
        load_planes(3'd7, 1'b1);
        send_object(vol(1'b1, 10, 0, 0, 0, 0, 0, 5));
        send_object(vol(1'b0, 1, 0, 0, 0, 9, 9, 0));
        send_object(vol(1'b0, 0, 0, 0, 0, 9, 9, 0));
        drain();

        // Random phases over plane styles and counts, gaps on both sides
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0:       style = PLANE_MIXED;
                1:       style = PLANE_AXIS;
                2:       style = PLANE_EXTREME;
                default: style = PLANE_UNIT;
            endcase
            for (int p = 0; p < NUM_PLANE_REGS; p++)
                plane_set[p] = make_plane(style);
            load_planes(phase_counts[ph], ph == 4);
            tx_steady = (ph % 3 == 1);
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                // hold off mid-phase until the unit has emptied
                if (ph % 2 == 0 && i == BEATS_PER_PHASE / 2)
                    drain();
                send_object(random_volume());
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
